@@ rtl/core/bdp_pkg.sv @@
// Shared types, constants and field widths for the 2x2 box downscale pyramid.
package bdp_pkg;

	// Geometry limits
	localparam int MAX_WIDTH    = 2048;
	localparam int NUM_CHANNELS = 3;
	localparam int MAX_STAGES   = 3;
	localparam int ROW_LIMIT    = 4096;

	// Field widths
	localparam int CH_W    = 8;
	localparam int PX_W    = NUM_CHANNELS * CH_W;
	localparam int SUM_W   = CH_W + 1;
	localparam int PAIR_W  = NUM_CHANNELS * SUM_W;
	localparam int TOT_W   = CH_W + 2;
	localparam int COL_W   = 11;
	localparam int ROW_W   = 12;
	localparam int WID_W   = 12;
	localparam int HGT_W   = 13;
	localparam int SCALE_W = 2;

	// Configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 13;
	localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SCALE_LOG2    = 2'd2;

	// Reset values of the configuration registers
	localparam logic [WID_W-1:0]   RST_SOURCE_WIDTH  = 12'd640;
	localparam logic [HGT_W-1:0]   RST_SOURCE_HEIGHT = 13'd480;
	localparam logic [SCALE_W-1:0] RST_SCALE_LOG2    = 2'd1;

	// Decoupling queue
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	// What one pyramid stage does with the pixel that reaches it
	typedef enum logic [2:0] {
		OP_IDLE,  // pixel does not reach this stage
		OP_LEFT,  // even column: hold as left sample
		OP_PAIR,  // odd column, even row: store horizontal pair sum
		OP_EMIT,  // odd column, odd row: emit block average
		OP_PASS   // stage beyond the selected count: forward unchanged
	} op_t;

	// One classified source pixel travelling from front to back
	typedef struct packed {
		logic [PX_W-1:0]            px;
		logic [COL_W-1:0]           col;
		op_t [MAX_STAGES-1:0]       ops;
		logic                       last;
	} item_t;

endpackage

@@ rtl/core/bdp_ram.sv @@
// Generic simple dual-port RAM with registered read data.
module bdp_ram #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 27
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write and read port; a read in the same cycle returns the old word
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

@@ rtl/core/bdp_front.sv @@
// Front end: configuration registers, raster position tracking, crop and stage classification.
module bdp_front
	import bdp_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  pix_valid,
	output logic                  pix_ready,
	input  logic [PX_W-1:0]       pix_data,
	output logic                  push_valid,
	input  logic                  push_ready,
	output item_t                 push_item
);

	logic [WID_W-1:0]   src_width_q;
	logic [HGT_W-1:0]   src_height_q;
	logic [SCALE_W-1:0] scale_q;
	logic [COL_W-1:0]   col_q;
	logic [ROW_W-1:0]   row_q;

	logic [SCALE_W-1:0] k;
	logic [WID_W-1:0]   w_eff;
	logic [WID_W-1:0]   tw;
	logic [HGT_W-1:0]   h_eff;
	logic [HGT_W-1:0]   th;
	logic               in_frame;
	logic               reach;
	logic               accept;
	logic [WID_W-1:0]   col_inc;
	logic [HGT_W-1:0]   row_inc;

	assign cfg_ready = 1'b1;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_width_q  <= RST_SOURCE_WIDTH;
			src_height_q <= RST_SOURCE_HEIGHT;
			scale_q      <= RST_SCALE_LOG2;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_SOURCE_WIDTH:  src_width_q  <= cfg_data[WID_W-1:0];
				CFG_SOURCE_HEIGHT: src_height_q <= cfg_data[HGT_W-1:0];
				CFG_SCALE_LOG2:    scale_q      <= cfg_data[SCALE_W-1:0];
				default: ;
			endcase
		end
	end

	// Effective geometry: clamp size, treat scale zero as one stage
	always_comb begin
		k     = (scale_q == '0) ? SCALE_W'(1) : scale_q;
		w_eff = (src_width_q > WID_W'(MAX_WIDTH)) ? WID_W'(MAX_WIDTH) : src_width_q;
		h_eff = (src_height_q > HGT_W'(ROW_LIMIT)) ? HGT_W'(ROW_LIMIT) : src_height_q;
		tw    = w_eff >> k;
		th    = h_eff >> k;
	end

	// Classify the current pixel: crop test, per-stage operation, frame end
	always_comb begin
		in_frame = (WID_W'(col_q) < (tw << k)) && (HGT_W'(row_q) < (th << k));
		push_item.px   = pix_data;
		push_item.col  = col_q;
		push_item.last = ((WID_W'(col_q) >> k) == (tw - WID_W'(1))) &&
		                 ((HGT_W'(row_q) >> k) == (th - HGT_W'(1)));
		reach = 1'b1;
		for (int s = 0; s < MAX_STAGES; s++) begin
			if (!reach) begin
				push_item.ops[s] = OP_IDLE;
			end else if (s >= int'(k)) begin
				push_item.ops[s] = OP_PASS;
			end else if (!col_q[s]) begin
				push_item.ops[s] = OP_LEFT;
			end else if (!row_q[s]) begin
				push_item.ops[s] = OP_PAIR;
			end else begin
				push_item.ops[s] = OP_EMIT;
			end
			if (s < int'(k)) begin
				reach = reach & col_q[s] & row_q[s];
			end
		end
	end

	// Cropped pixels are taken and dropped here
	assign pix_ready  = push_ready;
	assign accept     = pix_valid && pix_ready;
	assign push_valid = pix_valid && in_frame;

	assign col_inc = WID_W'(col_q) + WID_W'(1);
	assign row_inc = HGT_W'(row_q) + HGT_W'(1);

	// Advance raster position, wrap column then row
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (col_inc >= w_eff) begin
				col_q <= '0;
				row_q <= (row_inc >= h_eff) ? '0 : row_inc[ROW_W-1:0];
			end else begin
				col_q <= col_inc[COL_W-1:0];
			end
		end
	end

endmodule

@@ rtl/core/bdp_queue.sv @@
// Short queue that decouples the classifying front end from the filter pipeline.
module bdp_queue
	import bdp_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push_valid,
	output logic  push_ready,
	input  item_t push_item,
	output logic  pop_valid,
	input  logic  pop_ready,
	output item_t pop_item
);

	item_t             entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;
	logic              do_push;
	logic              do_pop;

	assign push_ready = (count_q != (QPTR_W+1)'(QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_item   = entry_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	// Store pushed entries
	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + (QPTR_W+1)'(1);
				2'b01:   count_q <= count_q - (QPTR_W+1)'(1);
				default: ;
			endcase
		end
	end

endmodule

@@ rtl/core/bdp_back.sv @@
// Back end: cascade of 2x2 box stages with line buffers, and the output register.
module bdp_back
	import bdp_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            pop_valid,
	output logic            pop_ready,
	input  item_t           pop_item,
	output logic            out_valid,
	input  logic            out_ready,
	output logic [PX_W-1:0] out_px,
	output logic            out_last
);

	// Horizontal pair sum per channel
	function automatic logic [PAIR_W-1:0] pair_sum(input logic [PX_W-1:0] left,
	                                               input logic [PX_W-1:0] px);
		logic [PAIR_W-1:0] acc;
		for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
			acc[ch*SUM_W +: SUM_W] = SUM_W'(left[ch*CH_W +: CH_W]) +
			                         SUM_W'(px[ch*CH_W +: CH_W]);
		end
		return acc;
	endfunction

	// Four-sample average per channel, truncating
	function automatic logic [PX_W-1:0] box_avg(input logic [PAIR_W-1:0] pair,
	                                            input logic [PX_W-1:0] left,
	                                            input logic [PX_W-1:0] px);
		logic [PX_W-1:0]  res;
		logic [TOT_W-1:0] tot;
		for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
			tot = TOT_W'(pair[ch*SUM_W +: SUM_W]) + TOT_W'(left[ch*CH_W +: CH_W]) +
			      TOT_W'(px[ch*CH_W +: CH_W]);
			res[ch*CH_W +: CH_W] = tot[TOT_W-1:2];
		end
		return res;
	endfunction

	logic              adv;
	item_t             in_item  [MAX_STAGES];
	logic              in_vld   [MAX_STAGES];
	item_t             stg_item_q [MAX_STAGES];
	logic              stg_vld_q  [MAX_STAGES];
	logic [PX_W-1:0]   left_q   [MAX_STAGES];
	logic [PAIR_W-1:0] rd_pair  [MAX_STAGES];
	logic [PX_W-1:0]   res_px   [MAX_STAGES];
	logic              res_vld  [MAX_STAGES];
	logic              out_vld_q;
	logic [PX_W-1:0]   out_px_q;
	logic              out_last_q;

	// Whole pipeline moves unless the output register is held
	assign adv       = !out_vld_q || out_ready;
	assign pop_ready = adv;

	assign in_item[0] = pop_item;
	assign in_vld[0]  = pop_valid;

	for (genvar g = 0; g < MAX_STAGES; g++) begin : g_stage
		localparam int DEPTH = MAX_WIDTH >> (g + 1);

		op_t op;
		assign op = stg_item_q[g].ops[g];

		// Feed from previous stage with its averaged pixel
		if (g > 0) begin : g_link
			always_comb begin
				in_item[g]    = stg_item_q[g-1];
				in_item[g].px = res_px[g-1];
			end
			assign in_vld[g] = res_vld[g-1];
		end

		// Line buffer: read as the pixel enters, write as it leaves
		bdp_ram #(
			.DEPTH (DEPTH),
			.WIDTH (PAIR_W)
		) u_line (
			.clk     (clk),
			.wr_en   (adv && stg_vld_q[g] && (op == OP_PAIR)),
			.wr_addr (stg_item_q[g].col[COL_W-1:g+1]),
			.wr_data (pair_sum(left_q[g], stg_item_q[g].px)),
			.rd_en   (adv),
			.rd_addr (in_item[g].col[COL_W-1:g+1]),
			.rd_data (rd_pair[g])
		);

		// Stage register
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				stg_vld_q[g] <= 1'b0;
			end else if (adv) begin
				stg_vld_q[g] <= in_vld[g];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				stg_item_q[g] <= in_item[g];
			end
		end

		// Hold the left sample of the current pair
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				left_q[g] <= '0;
			end else if (adv && stg_vld_q[g] && (op == OP_LEFT)) begin
				left_q[g] <= stg_item_q[g].px;
			end
		end

		// Stage result
		always_comb begin
			case (op)
				OP_EMIT: res_px[g] = box_avg(rd_pair[g], left_q[g], stg_item_q[g].px);
				default: res_px[g] = stg_item_q[g].px;
			endcase
			res_vld[g] = stg_vld_q[g] && ((op == OP_EMIT) || (op == OP_PASS));
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv) begin
			out_vld_q <= res_vld[MAX_STAGES-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_px_q   <= res_px[MAX_STAGES-1];
			out_last_q <= stg_item_q[MAX_STAGES-1].last;
		end
	end

	assign out_valid = out_vld_q;
	assign out_px    = out_px_q;
	assign out_last  = out_last_q;

endmodule

@@ rtl/core/box_downscale_pyramid_rgb_top.sv @@
// Top level of the RGB 2x2 box downscale pyramid (factor 2, 4 or 8).
// Throughput: one source pixel per cycle unless the output stalls; one target pixel per 4^k
//   source pixels in frame. A result reaches m_axis_tvalid from its last source pixel through
//   the queue, the three stage registers with their line-buffer reads and the output register.
// Stages beyond the selected count pass pixels on, so latency does not depend on the scale.
// Reset: arst_n clears positions, pipeline and queue and loads 640x480, scale 2; line buffers
//   are not cleared, and the block is ready on the first cycle after reset.
module box_downscale_pyramid_rgb_top
	import bdp_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	// Configuration write channel
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	// Source pixels
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [PX_W-1:0]       s_axis_tdata,  // in_red [7:0], in_green [15:8], in_blue [23:16]
	// Target pixels
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [PX_W-1:0]       m_axis_tdata,  // out_red [7:0], out_green [15:8], out_blue [23:16]
	output logic                  m_axis_tlast   // frame_end
);

	logic  push_valid;
	logic  push_ready;
	item_t push_item;
	logic  pop_valid;
	logic  pop_ready;
	item_t pop_item;

	bdp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.pix_valid  (s_axis_tvalid),
		.pix_ready  (s_axis_tready),
		.pix_data   (s_axis_tdata),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item)
	);

	bdp_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_item   (pop_item)
	);

	bdp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_item  (pop_item),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_px    (m_axis_tdata),
		.out_last  (m_axis_tlast)
	);

endmodule

@@ rtl/core/bdp_checker.sv @@
// Port-level checker for the box downscale pyramid, bound to the top level.
module bdp_checker
	import bdp_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  cfg_valid,
	input logic                  cfg_ready,
	input logic                  s_axis_tvalid,
	input logic                  s_axis_tready,
	input logic                  m_axis_tvalid,
	input logic                  m_axis_tready,
	input logic [PX_W-1:0]       m_axis_tdata,
	input logic                  m_axis_tlast
);

	// Held result keeps its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
		else $error("result changed while stalled");

	// With the output register empty the pipeline drains, so the input side frees up
	a_in_free: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |=> s_axis_tready)
		else $error("input blocked although output side is idle");

	// Configuration writes are never stalled
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("configuration write stalled");

	// No result can appear in the first cycle after reset
	a_reset_quiet: assert property (@(posedge clk)
		$rose(arst_n) |-> !m_axis_tvalid)
		else $error("result present right after reset");

endmodule

bind box_downscale_pyramid_rgb_top bdp_checker u_bdp_checker (.*);
